[sv/rau_pkg.sv]
// Shared types and constants for the rational arithmetic unit
package rau_pkg;

  localparam int unsigned FieldW = 32;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_MUL = 2'd1,
    ACT_EQ  = 2'd2,
    ACT_RED = 2'd3
  } action_e;

  // request to the shared divider
  typedef struct packed {
    logic start;
  } div_ctl_t;

endpackage

[sv/rau_if.sv]
// Valid/ready channel interfaces for operand and result words
interface rau_in_if;
  import rau_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic signed [31:0] a_num;
  logic signed [31:0] a_den;
  logic signed [31:0] b_num;
  logic signed [31:0] b_den;
  modport source (output valid, action, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, action, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_num;
  logic signed [31:0] res_den;
  logic               is_equal;
  logic               bad_denominator;
  modport source (output valid, res_num, res_den, is_equal, bad_denominator, input ready);
  modport sink   (input valid, res_num, res_den, is_equal, bad_denominator, output ready);
endinterface

[sv/rau_div.sv]
// Restoring signed divider, one quotient bit per cycle, C truncation semantics
module rau_div #(
  parameter int unsigned W = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rau_pkg::div_ctl_t    ctl_i,
  input  logic [W-1:0]         dividend_i,
  input  logic [W-1:0]         divisor_i,
  output logic                 done_o,
  output logic [W-1:0]         quot_o,
  output logic [W-1:0]         rem_o
);
  import rau_pkg::*;

  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    rem_q, quo_q, dsr_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, qneg_q, rneg_q, zero_q, done_q;
  logic [W-1:0]    dvd_a, dsr_a;
  logic [W:0]      trial;
  logic [W:0]      shifted;

  assign dvd_a   = dividend_i[W-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign dsr_a   = divisor_i[W-1] ? (~divisor_i + 1'b1) : divisor_i;
  assign shifted = {rem_q, quo_q[W-1]};
  assign trial   = shifted - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(W);
        rem_q  <= '0;
        quo_q  <= dvd_a;
        dsr_q  <= dsr_a;
        qneg_q <= dividend_i[W-1] ^ divisor_i[W-1];
        rneg_q <= dividend_i[W-1];
        zero_q <= (divisor_i == '0);
      end else if (busy_q) begin
        if (!trial[W]) begin
          rem_q <= trial[W-1:0];
          quo_q <= {quo_q[W-2:0], 1'b1};
        end else begin
          rem_q <= shifted[W-1:0];
          quo_q <= {quo_q[W-2:0], 1'b0};
        end
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // divisor zero: quotient 0, remainder = dividend (shifted whole into rem_q)
  always_comb begin
    if (zero_q) begin
      quot_o = '0;
      rem_o  = rneg_q ? (~rem_q + 1'b1) : rem_q;
    end else begin
      quot_o = qneg_q ? (~quo_q + 1'b1) : quo_q;
      rem_o  = rneg_q ? (~rem_q + 1'b1) : rem_q;
    end
  end
  assign done_o = done_q;

endmodule

[sv/rational_arithmetic_unit.sv]
// Top level: sequencer around one shared multiplier and one shared divider
// Every gcd step, every reduction and every lcm quotient is a pass through the
// single bit-serial divider (a start, one iteration per quotient bit, a done
// strobe); the work per word is set by the number of divides (Euclid remainder
// steps, up to about 47 per gcd and two gcds for the equality test, plus 2 to 4
// quotients). Each product is registered by the state that uses it. The input
// is ready only while the sequencer is idle; a finished result moves into its
// own output register, so a word waiting there stalls the sequencer only once
// the next one is done.
module rational_arithmetic_unit #(
  parameter int unsigned WIDTH = 32
) (
  input logic clk_i,
  input logic rst_ni,
  rau_in_if.sink    in_i,
  rau_out_if.source out_o
);
  import rau_pkg::*;

  localparam int unsigned W = WIDTH;

  typedef enum logic [4:0] {
    S_IDLE, S_GCD, S_GCD_W, S_RED_N, S_RED_NW, S_RED_D, S_RED_DW,
    S_ADD_M1, S_ADD_D1, S_ADD_D1W, S_ADD_M2, S_ADD_D2, S_ADD_D2W,
    S_ADD_M3, S_ADD_D3, S_ADD_D3W, S_ADD_FIN, S_MUL, S_OUT
  } state_e;

  // what to do after a reduction finishes
  typedef enum logic [1:0] {
    R_OUT, R_EQ_B, R_EQ_CMP
  } red_next_e;

  state_e       state_q;
  red_next_e    rnext_q;
  logic [1:0]   act_q;
  logic [W-1:0] an_q, ad_q, bn_q, bd_q;
  logic [W-1:0] m_q, n_q;      // gcd working pair
  logic [W-1:0] fn_q, fd_q;    // fraction being reduced
  logic [W-1:0] g_q, cd_q, t1_q, rn_q, rd_q, ran_q, rad_q, tmp_q;
  logic         bad_q, eq_q, ovalid_q;
  logic [W-1:0] onum_q, oden_q;
  logic         oeq_q, obad_q;

  logic [W-1:0] mul_a, mul_b, mul_p;
  logic [W-1:0] div_n, div_d, div_q, div_r;
  logic         div_done;
  div_ctl_t     div_ctl;

  logic [W-1:0] in_an, in_ad, in_bn, in_bd;

  assign in_an = W'(in_i.a_num);
  assign in_ad = W'(in_i.a_den);
  assign in_bn = W'(in_i.b_num);
  assign in_bd = W'(in_i.b_den);

  assign mul_p = W'(mul_a * mul_b);

  rau_div #(.W(W)) u_div (
    .clk_i, .rst_ni,
    .ctl_i(div_ctl),
    .dividend_i(div_n),
    .divisor_i(div_d),
    .done_o(div_done),
    .quot_o(div_q),
    .rem_o(div_r)
  );

  // operand selection for the shared units
  always_comb begin
    mul_a = ad_q;
    mul_b = bd_q;
    div_n = m_q;
    div_d = n_q;
    div_ctl.start = 1'b0;
    unique case (state_q)
      S_ADD_M2: begin mul_a = an_q; mul_b = cd_q; end
      S_ADD_M3: begin mul_a = bn_q; mul_b = cd_q; end
      S_MUL:    begin mul_a = an_q; mul_b = bn_q; end
      default: ;
    endcase
    unique case (state_q)
      S_GCD:    begin div_n = m_q;  div_d = n_q;  div_ctl.start = (n_q != '0); end
      S_RED_N:  begin div_n = fn_q; div_d = g_q;  div_ctl.start = 1'b1; end
      S_RED_D:  begin div_n = fd_q; div_d = g_q;  div_ctl.start = 1'b1; end
      S_ADD_D1: begin div_n = tmp_q; div_d = g_q; div_ctl.start = 1'b1; end
      S_ADD_D2: begin div_n = tmp_q; div_d = ad_q; div_ctl.start = 1'b1; end
      S_ADD_D3: begin div_n = tmp_q; div_d = bd_q; div_ctl.start = 1'b1; end
      default: ;
    endcase
  end

  assign in_i.ready            = (state_q == S_IDLE);
  assign out_o.valid           = ovalid_q;
  assign out_o.res_num         = 32'(signed'(onum_q));
  assign out_o.res_den         = 32'(signed'(oden_q));
  assign out_o.is_equal        = oeq_q;
  assign out_o.bad_denominator = obad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rnext_q  <= R_OUT;
      ovalid_q <= 1'b0;
      onum_q   <= '0;
      oden_q   <= '0;
      oeq_q    <= 1'b0;
      obad_q   <= 1'b0;
    end else begin
      // output register: loaded from the finished word, freed on handshake
      if ((state_q == S_OUT) && (!ovalid_q || out_o.ready)) begin
        ovalid_q <= 1'b1;
        onum_q   <= rn_q;
        oden_q   <= rd_q;
        oeq_q    <= eq_q;
        obad_q   <= bad_q;
      end else if (out_o.valid && out_o.ready) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: if (in_i.valid) begin
          act_q <= in_i.action;
          eq_q  <= 1'b0;
          rn_q  <= '0;
          rd_q  <= W'(1);
          bad_q <= (in_ad == '0) ||
                   ((in_i.action != ACT_RED) && (in_bd == '0));
          an_q  <= (in_ad == '0) ? '0 : in_an;
          ad_q  <= (in_ad == '0) ? W'(1) : in_ad;
          bn_q  <= (in_bd == '0) ? '0 : in_bn;
          bd_q  <= (in_bd == '0) ? W'(1) : in_bd;
          unique case (action_e'(in_i.action))
            ACT_ADD: begin
              m_q <= (in_ad == '0) ? W'(1) : in_ad;
              n_q <= (in_bd == '0) ? W'(1) : in_bd;
              state_q <= S_GCD;
              rnext_q <= R_OUT;
            end
            ACT_MUL: state_q <= S_MUL;
            ACT_EQ, ACT_RED: begin
              fn_q <= (in_ad == '0) ? '0 : in_an;
              fd_q <= (in_ad == '0) ? W'(1) : in_ad;
              m_q  <= (in_ad == '0) ? '0 : in_an;
              n_q  <= (in_ad == '0) ? W'(1) : in_ad;
              rnext_q <= (in_i.action == ACT_EQ) ? R_EQ_B : R_OUT;
              state_q <= S_GCD;
            end
            default: ;
          endcase
        end
        S_MUL: begin
          // product denominator needs the multiplier too: take it next
          fn_q <= mul_p;
          m_q  <= mul_p;
          state_q <= S_ADD_FIN;
        end
        S_GCD: begin
          if (n_q == '0) begin
            g_q <= m_q;
            state_q <= (act_q == ACT_ADD) ? S_ADD_M1 : S_RED_N;
          end else begin
            state_q <= S_GCD_W;
          end
        end
        S_GCD_W: if (div_done) begin
          m_q <= n_q;
          n_q <= div_r;
          state_q <= S_GCD;
        end
        S_RED_N:  state_q <= S_RED_NW;
        S_RED_NW: if (div_done) begin
          tmp_q <= div_q;
          state_q <= S_RED_D;
        end
        S_RED_D:  state_q <= S_RED_DW;
        S_RED_DW: if (div_done) begin
          if (div_q == '0) begin
            bad_q <= 1'b1;
            ran_q <= '0;
            rad_q <= W'(1);
          end else begin
            ran_q <= tmp_q;
            rad_q <= div_q;
          end
          unique case (rnext_q)
            R_EQ_B: begin
              fn_q <= bn_q; fd_q <= bd_q; m_q <= bn_q; n_q <= bd_q;
              rnext_q <= R_EQ_CMP;
              state_q <= S_GCD;
            end
            R_EQ_CMP: begin
              eq_q <= (ran_q == ((div_q == '0) ? '0 : tmp_q)) &&
                      (rad_q == ((div_q == '0) ? W'(1) : div_q));
              state_q <= S_OUT;
            end
            default: begin
              rn_q <= (div_q == '0) ? '0 : tmp_q;
              rd_q <= (div_q == '0) ? W'(1) : div_q;
              state_q <= S_OUT;
            end
          endcase
        end
        S_ADD_M1: begin
          tmp_q <= mul_p;   // ad*bd
          state_q <= S_ADD_D1;
        end
        S_ADD_D1:  state_q <= S_ADD_D1W;
        S_ADD_D1W: if (div_done) begin
          cd_q <= div_q;
          state_q <= S_ADD_M2;
        end
        S_ADD_M2: begin tmp_q <= mul_p; state_q <= S_ADD_D2; end
        S_ADD_D2:  state_q <= S_ADD_D2W;
        S_ADD_D2W: if (div_done) begin
          t1_q <= div_q;
          state_q <= S_ADD_M3;
        end
        S_ADD_M3: begin tmp_q <= mul_p; state_q <= S_ADD_D3; end
        S_ADD_D3:  state_q <= S_ADD_D3W;
        S_ADD_D3W: if (div_done) begin
          if (cd_q == '0) begin
            bad_q <= 1'b1;
            rn_q  <= '0;
            rd_q  <= W'(1);
          end else begin
            rn_q <= t1_q + div_q;
            rd_q <= cd_q;
          end
          state_q <= S_OUT;
        end
        S_ADD_FIN: begin
          // multiply path: denominator product ready (mul defaults to ad*bd)
          if (mul_p == '0) begin
            bad_q <= 1'b1;
            fn_q <= '0; fd_q <= W'(1); m_q <= '0; n_q <= W'(1);
          end else begin
            fd_q <= mul_p; n_q <= mul_p;
          end
          rnext_q <= R_OUT;
          state_q <= S_GCD;
        end
        S_OUT: if (!ovalid_q || out_o.ready) begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[dv/rational_arithmetic_unit_test.sv]
// Self-checking testbench for the rational arithmetic unit: random and directed fraction words
module rational_arithmetic_unit_test;
  import rau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [31:0] word_t;

  typedef struct {
    action_e act;
    word_t   an, ad, bn, bd;
    int      phase;
    bit      drain;    // hold back until every result is home
  } op_word_t;

  typedef struct {
    word_t num, den;
    bit    eq, bad;
  } frac_res_t;

  typedef struct {
    word_t n, d;
  } frac_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rau_in_if  in_bus();
  rau_out_if out_bus();

  rational_arithmetic_unit dut (
    .clk_i(clk), .rst_ni(rst_n), .in_i(in_bus), .out_o(out_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  op_word_t  pending_ops[$];
  frac_res_t expected_res[$];
  int phase = 0;
  int n_sent = 0, n_checked = 0, n_mismatch = 0;
  int n_bad_seen = 0, n_eq_seen = 0;
  int hold_left = 0;
  bit hold_done = 0;
  int op_count[4] = '{0, 0, 0, 0};

  // ---------------- fraction predictor ----------------
  function automatic word_t mag(word_t v);
    return v[31] ? -v : v;
  endfunction

  function automatic word_t tdiv(word_t a, word_t b);
    word_t q;
    if (b == 0) return 0;
    q = mag(a) / mag(b);
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  function automatic word_t trem(word_t a, word_t b);
    word_t r;
    if (b == 0) return a;
    r = mag(a) % mag(b);
    return a[31] ? -r : r;
  endfunction

  function automatic word_t euclid(word_t m, word_t n);
    word_t t;
    while (n != 0) begin
      t = trem(m, n);
      m = n;
      n = t;
    end
    return m;
  endfunction

  function automatic frac_t mk(word_t n, word_t d, ref bit bad);
    frac_t f;
    if (d == 0) begin
      bad = 1;
      f.n = 0;
      f.d = 1;
    end else begin
      f.n = n;
      f.d = d;
    end
    return f;
  endfunction

  function automatic frac_t lowest_terms(frac_t f, ref bit bad);
    word_t g;
    g = euclid(f.n, f.d);
    return mk(tdiv(f.n, g), tdiv(f.d, g), bad);
  endfunction

  function automatic frac_res_t fraction_result(op_word_t w);
    frac_res_t res;
    frac_t a, b, r, ra, rb;
    word_t g, cd, t1, t2;
    bit bad, eq;
    bad = 0;
    eq = 0;
    a = mk(w.an, w.ad, bad);
    r.n = 0;
    r.d = 1;
    if (w.act == ACT_RED) begin
      r = lowest_terms(a, bad);
    end else begin
      b = mk(w.bn, w.bd, bad);
      case (w.act)
        ACT_ADD: begin
          g  = euclid(a.d, b.d);
          cd = tdiv(a.d * b.d, g);
          t1 = tdiv(a.n * cd, a.d);
          t2 = tdiv(b.n * cd, b.d);
          r  = mk(t1 + t2, cd, bad);
        end
        ACT_MUL: begin
          r = mk(a.n * b.n, a.d * b.d, bad);
          r = lowest_terms(r, bad);
        end
        default: begin
          ra = lowest_terms(a, bad);
          rb = lowest_terms(b, bad);
          eq = (ra.n == rb.n) && (ra.d == rb.d);
        end
      endcase
    end
    res.num = r.n;
    res.den = r.d;
    res.eq  = eq;
    res.bad = bad;
    return res;
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk or negedge rst_n) begin
    op_word_t w;
    frac_res_t e;
    bit accepted;
    if (!rst_n) begin
      in_bus.valid  <= 1'b0;
      in_bus.action <= ACT_ADD;
      in_bus.a_num  <= '0;
      in_bus.a_den  <= '0;
      in_bus.b_num  <= '0;
      in_bus.b_den  <= '0;
    end else begin
      accepted = in_bus.valid && in_bus.ready;
      if (accepted) begin
        w.act = action_e'(in_bus.action);
        w.an = in_bus.a_num;
        w.ad = in_bus.a_den;
        w.bn = in_bus.b_num;
        w.bd = in_bus.b_den;
        e = fraction_result(w);
        expected_res.push_back(e);
        n_sent <= n_sent + 1;
        op_count[w.act] += 1;
      end
      if (!in_bus.valid || accepted) begin
        if (pending_ops.size() > 0 &&
            !(pending_ops[0].drain && (accepted || expected_res.size() != 0)) &&
            !(pending_ops[0].phase inside {1, 3} && $urandom_range(99) < 79)) begin
          w = pending_ops.pop_front();
          phase         <= w.phase;
          in_bus.valid  <= 1'b1;
          in_bus.action <= w.act;
          in_bus.a_num  <= w.an;
          in_bus.a_den  <= w.ad;
          in_bus.b_num  <= w.bn;
          in_bus.b_den  <= w.bd;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, once, while the sender keeps offering
  always @(posedge clk) begin
    if (!hold_done && n_sent == 40) begin
      hold_left <= 10000;
      hold_done <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk or negedge rst_n) begin
    frac_res_t e;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_res.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("unexpected result word: %h/%h eq=%b bad=%b", out_bus.res_num,
                     out_bus.res_den, out_bus.is_equal, out_bus.bad_denominator);
        end else begin
          e = expected_res.pop_front();
          n_checked++;
          if (e.bad) n_bad_seen++;
          if (e.eq) n_eq_seen++;
          if (out_bus.res_num !== e.num || out_bus.res_den !== e.den ||
              out_bus.is_equal !== e.eq || out_bus.bad_denominator !== e.bad) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("mismatch word %0d: exp %h/%h eq=%b bad=%b got %h/%h eq=%b bad=%b",
                       n_checked, e.num, e.den, e.eq, e.bad, out_bus.res_num,
                       out_bus.res_den, out_bus.is_equal, out_bus.bad_denominator);
          end
        end
      end
      out_bus.ready <= (hold_left == 0) &&
                       !(phase inside {2, 3} && $urandom_range(99) < 79);
    end
  end

  // ---------------- stimulus ----------------
  function automatic word_t pick_val();
    case ($urandom_range(9))
      0, 1, 2: return $urandom;
      3:       return 32'h8000_0000;
      4:       return 32'h7fff_ffff;
      5:       return 0;
      6:       return -word_t'($urandom_range(1, 300));
      7:       return word_t'($urandom_range(1, 65536)) << $urandom_range(0, 16);
      default: return word_t'($urandom_range(1, 300));
    endcase
  endfunction

  task automatic add_op(action_e act, word_t an, word_t ad, word_t bn, word_t bd,
                        int ph, bit drain = 0);
    op_word_t w;
    w.act = act;
    w.an = an;
    w.ad = ad;
    w.bn = bn;
    w.bd = bd;
    w.phase = ph;
    w.drain = drain;
    pending_ops.push_back(w);
  endtask

  initial begin
    word_t x;
    // directed: extremes, zero denominators, wrap cases, negative gcd
    add_op(ACT_ADD, 1, 2, 1, 3, 0);
    add_op(ACT_ADD, -1, 4, 3, -6, 0);
    add_op(ACT_ADD, 1, 0, 1, 2, 0);
    add_op(ACT_ADD, 1, 65536, 1, 65536, 0);     // lcm wraps to zero
    add_op(ACT_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1, 0);
    add_op(ACT_ADD, 32'h8000_0000, -1, 1, 32'h8000_0000, 0);
    add_op(ACT_MUL, 2, 3, 9, 4, 0);
    add_op(ACT_MUL, 1, 65536, 1, 65536, 0);     // denominator product wraps to zero
    add_op(ACT_MUL, 32'h8000_0000, -1, -1, 1, 0);
    add_op(ACT_MUL, 5, 0, 3, 0, 0);
    add_op(ACT_MUL, -6, 4, 2, -3, 0);
    add_op(ACT_MUL, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0);
    add_op(ACT_EQ, 1, 2, 2, 4, 0);
    add_op(ACT_EQ, 1, 2, -1, -2, 0);
    add_op(ACT_EQ, 1, 0, 0, 5, 0);
    add_op(ACT_EQ, 3, 7, 3, 8, 0);
    add_op(ACT_EQ, 32'h8000_0000, 32'h8000_0000, 1, 1, 0);
    add_op(ACT_RED, 6, -4, 0, 0, 0);            // positive gcd, signs kept
    add_op(ACT_RED, -6, 4, 1, 1, 0);
    add_op(ACT_RED, 0, 0, 32'hffff_ffff, 32'hffff_ffff, 0);
    add_op(ACT_RED, 32'h8000_0000, -1, 0, 0, 0);
    add_op(ACT_RED, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
    add_op(ACT_RED, 0, 7, 0, 0, 0);
    add_op(ACT_RED, 32'h7fff_ffff, 32'h7fff_fffe, 0, 0, 0);
    // random, in four phases: no idling, idle sender, idle receiver, both
    for (int i = 0; i < 116; i++) begin
      add_op(action_e'($urandom_range(3)), pick_val(), pick_val(), pick_val(), pick_val(),
             i / 29, (i == 10) || (i == 70));
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk);
    while (pending_ops.size() != 0 || in_bus.valid || expected_res.size() != 0);
    repeat (4200) @(posedge clk);
    $display("Checked %0d result words (add %0d, mul %0d, eq %0d, reduce %0d)",
             n_checked, op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("%0d with a replaced denominator, %0d equal pairs, %0d mismatches",
             n_bad_seen, n_eq_seen, n_mismatch);
    if (n_mismatch == 0 && expected_res.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timed out with %0d result words outstanding", expected_res.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
